>>> rtl/klst_pkg.sv
// klst_pkg: types, codes and constants for the keyed light slot table.
// Used by every module of the block; depends on nothing.
package klst_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int TIME_W      = 48;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] STAT_KEY  = 2'd0;
    localparam logic [1:0] STAT_FREE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_DONE = 2'd3;

    localparam logic [5:0] COUNT_MAX = 6'd63;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        owner_key;
        logic [4:0]         slot_index;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [23:0]        start_radius;
        logic [15:0]        red_level;
        logic [15:0]        green_level;
        logic [15:0]        blue_level;
        logic [15:0]        decay_rate;
        logic [15:0]        duration;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         slot_used;
        logic [5:0]         active_count;
        logic [15:0]        entry_key;
        logic [23:0]        entry_radius;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] entry_z;
        logic [15:0]        entry_red;
        logic [15:0]        entry_green;
        logic [15:0]        entry_blue;
    } rsp_t;

    typedef struct packed {
        logic [15:0]        key;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [23:0]        radius;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic [15:0]        decay;
        logic [TIME_W-1:0]  death;
    } entry_t;

    // memory port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } mem_ctl_t;

    // per-entry outcome of the decay unit
    typedef struct packed {
        logic vld;
        logic wr;
        logic live;
    } upd_t;

endpackage

>>> rtl/klst_mem.sv
// klst_mem: entry memory of the light table with one valid bit per entry.
// Uses klst_pkg types; an entry whose valid bit is clear reads as all zero.
module klst_mem #(
    parameter int ENTRIES = klst_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  klst_pkg::mem_ctl_t ctl,
    input  logic [IW-1:0]     rd_addr,
    output klst_pkg::entry_t  rd_data,
    input  logic [IW-1:0]     wr_addr,
    input  klst_pkg::entry_t  wr_data
);

    klst_pkg::entry_t mem [ENTRIES];
    klst_pkg::entry_t rdata_reg;
    logic [ENTRIES-1:0] vld_reg;
    logic               rvld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : '0;

endmodule

>>> rtl/klst_decay.sv
// klst_decay: shared per-entry unit for the tick walk: expiry compare, decay
// multiply, then saturating radius update. Uses klst_pkg types.
module klst_decay #(
    parameter int ENTRIES = klst_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_vld,
    input  logic [IW-1:0]                 in_idx,
    input  klst_pkg::entry_t              in_ent,
    input  logic [klst_pkg::TIME_W-1:0]   now_time,
    input  logic [15:0]                   dur,
    output klst_pkg::upd_t                upd,
    output logic [IW-1:0]                 out_idx,
    output klst_pkg::entry_t              out_ent
);

    logic             vld_reg;
    logic [IW-1:0]    idx_reg;
    klst_pkg::entry_t ent_reg;
    logic             exp_reg;
    logic             use_reg;
    logic [31:0]      loss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            idx_reg  <= in_idx;
            ent_reg  <= in_ent;
            exp_reg  <= (in_ent.death < now_time);
            use_reg  <= (in_ent.radius != 24'd0);
            loss_reg <= 32'(dur) * 32'(in_ent.decay);
        end
    end

    always_comb
    begin
        out_ent = ent_reg;
        if (exp_reg || (loss_reg >= {8'd0, ent_reg.radius}))
        begin
            out_ent.radius = 24'd0;
        end
        else
        begin
            out_ent.radius = ent_reg.radius - loss_reg[23:0];
        end
        upd.vld  = vld_reg;
        upd.wr   = vld_reg && use_reg;
        upd.live = vld_reg && use_reg && !exp_reg;
    end

    assign out_idx = idx_reg;

endmodule

>>> rtl/keyed_light_slot_table_unit.sv
// keyed_light_slot_table_unit: sequencer of the light table; walks the entry
// memory one entry per cycle. Uses klst_pkg, klst_mem and klst_decay.
// Allocate and tick read every entry in turn and then drain the reads; tick also
// passes each read through the decay stage; read goes via ST_RD, clear to ST_FIN.
// One request at a time; busy drops as done rises, so the next request is taken
// while the result is shown. Async reset (rst_n low) empties table, time, count.
module keyed_light_slot_table_unit #(
    parameter int ENTRIES = klst_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  klst_pkg::req_t request,
    output logic           done,
    output klst_pkg::rsp_t result
);

    localparam int IW = $clog2(ENTRIES);
    localparam int XW = (IW > 5) ? IW : 5;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]                    state_reg, state_next;
    klst_pkg::req_t                req_reg;
    logic [IW-1:0]                 scan_reg;
    logic                          rd_pend_reg;
    logic [IW-1:0]                 rd_idx_reg;
    logic [5:0]                    cnt_reg;
    logic [5:0]                    live_reg;
    logic [klst_pkg::TIME_W-1:0]   now_reg;
    logic                          mfound_reg, ffound_reg;
    logic [IW-1:0]                 midx_reg, fidx_reg;
    logic                          done_reg;
    klst_pkg::rsp_t                result_reg, result_next;

    klst_pkg::mem_ctl_t ctl;
    logic [IW-1:0]      rd_addr, wr_addr;
    klst_pkg::entry_t   rd_data, wr_data, new_ent, dk_ent;
    klst_pkg::upd_t     upd;
    logic [IW-1:0]      dk_idx;

    logic               accept;
    logic               is_alloc, is_tick, is_read, is_clear;
    logic [XW-1:0]      slot_ext, found_ext;
    logic               in_range;
    logic               found;
    logic [IW-1:0]      found_idx;
    logic               key_hit, free_hit;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign is_alloc = (req_reg.opcode == klst_pkg::OP_ALLOC);
    assign is_tick  = (req_reg.opcode == klst_pkg::OP_TICK);
    assign is_read  = (req_reg.opcode == klst_pkg::OP_READ);
    assign is_clear = (req_reg.opcode == klst_pkg::OP_CLEAR);

    assign slot_ext  = XW'(req_reg.slot_index);
    assign in_range  = (9'(req_reg.slot_index) < 9'(ENTRIES));
    assign found     = mfound_reg || ffound_reg;
    assign found_idx = mfound_reg ? midx_reg : fidx_reg;
    assign found_ext = XW'(found_idx);

    assign key_hit  = (req_reg.owner_key != 16'd0) && (rd_data.key == req_reg.owner_key);
    assign free_hit = (rd_data.radius == 24'd0);

    always_comb
    begin
        new_ent.key    = req_reg.owner_key;
        new_ent.pos_x  = req_reg.origin_x;
        new_ent.pos_y  = req_reg.origin_y;
        new_ent.pos_z  = req_reg.origin_z;
        new_ent.radius = req_reg.start_radius;
        new_ent.red    = req_reg.red_level;
        new_ent.green  = req_reg.green_level;
        new_ent.blue   = req_reg.blue_level;
        new_ent.decay  = req_reg.decay_rate;
        new_ent.death  = now_reg + klst_pkg::TIME_W'(req_reg.duration);
    end

    // memory port steering
    always_comb
    begin
        ctl.rd_en = (state_reg == ST_SCAN) || (state_reg == ST_RD);
        ctl.clr   = (state_reg == ST_FIN) && is_clear;
        ctl.wr_en = upd.wr || ((state_reg == ST_FIN) && is_alloc && found);
        rd_addr   = (state_reg == ST_SCAN) ? scan_reg : slot_ext[IW-1:0];
        wr_addr   = upd.wr ? dk_idx : found_idx;
        wr_data   = upd.wr ? dk_ent : new_ent;
    end

    klst_mem #(
        .ENTRIES(ENTRIES)
    ) u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    klst_decay #(
        .ENTRIES(ENTRIES)
    ) u_decay (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (rd_pend_reg && is_tick),
        .in_idx  (rd_idx_reg),
        .in_ent  (rd_data),
        .now_time(now_reg),
        .dur     (req_reg.duration),
        .upd     (upd),
        .out_idx (dk_idx),
        .out_ent (dk_ent)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (request.opcode) inside
                        klst_pkg::OP_ALLOC, klst_pkg::OP_TICK: state_next = ST_SCAN;
                        klst_pkg::OP_READ:                     state_next = ST_RD;
                        default:                               state_next = ST_FIN;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == IW'(ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_pend_reg && !upd.vld)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RD:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next              = '0;
        result_next.status       = klst_pkg::STAT_DONE;
        result_next.active_count = is_tick ? cnt_reg : live_reg;
        if (is_alloc)
        begin
            if (found)
            begin
                result_next.status    = mfound_reg ? klst_pkg::STAT_KEY : klst_pkg::STAT_FREE;
                result_next.slot_used = found_ext[4:0];
            end
            else
            begin
                result_next.status = klst_pkg::STAT_FULL;
            end
        end
        else if (is_read)
        begin
            result_next.slot_used = req_reg.slot_index;
            if (in_range)
            begin
                result_next.entry_key    = rd_data.key;
                result_next.entry_radius = rd_data.radius;
                result_next.entry_x      = rd_data.pos_x;
                result_next.entry_y      = rd_data.pos_y;
                result_next.entry_z      = rd_data.pos_z;
                result_next.entry_red    = rd_data.red;
                result_next.entry_green  = rd_data.green;
                result_next.entry_blue   = rd_data.blue;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scan_reg    <= '0;
            rd_pend_reg <= 1'b0;
            cnt_reg     <= '0;
            live_reg    <= '0;
            now_reg     <= '0;
            mfound_reg  <= 1'b0;
            ffound_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            done_reg    <= (state_reg == ST_FIN);
            if (accept)
            begin
                scan_reg   <= '0;
                cnt_reg    <= '0;
                mfound_reg <= 1'b0;
                ffound_reg <= 1'b0;
                if (request.opcode == klst_pkg::OP_TICK)
                begin
                    now_reg <= now_reg + klst_pkg::TIME_W'(request.duration);
                end
            end
            else
            begin
                if (state_reg == ST_SCAN)
                begin
                    scan_reg <= scan_reg + IW'(1);
                end
                // first key match and first free entry, in index order
                if (rd_pend_reg && is_alloc)
                begin
                    if (key_hit && !mfound_reg)
                    begin
                        mfound_reg <= 1'b1;
                    end
                    if (free_hit && !ffound_reg)
                    begin
                        ffound_reg <= 1'b1;
                    end
                end
                if (upd.live && (cnt_reg != klst_pkg::COUNT_MAX))
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                if ((state_reg == ST_FIN) && is_tick)
                begin
                    live_reg <= cnt_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        rd_idx_reg <= scan_reg;
        if (rd_pend_reg && is_alloc)
        begin
            if (key_hit && !mfound_reg)
            begin
                midx_reg <= rd_idx_reg;
            end
            if (free_hit && !ffound_reg)
            begin
                fidx_reg <= rd_idx_reg;
            end
        end
        if (state_reg == ST_FIN)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
